@@ src/mscb_pkg.sv @@
// ----------------------------------------------------------------------------
// mscb_pkg
// shared types and constants of the multi-stream beat clock
// ----------------------------------------------------------------------------
package mscb_pkg;

	localparam int CD_W          = 34;     // countdown width, signed fixed point
	localparam int PERIOD_W      = 32;     // period register width, unsigned
	localparam int KIND_W        = 3;
	localparam int RESET_SAMPLES = 22050;  // reset period in whole samples

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE    = 3'd0,
		KIND_ARM       = 3'd1,
		KIND_PAUSE     = 3'd2,
		KIND_RESUME    = 3'd3,
		KIND_TAP_START = 3'd4,
		KIND_TAP_END   = 3'd5
	} kind_t;

	// per-transaction commands from the control unit to every lane
	typedef struct packed {
		logic set_one;  // load countdown with one sample
		logic step;     // ordinary sample step
		logic trig;     // trigger sample: reset to one sample and step at once
	} lane_ctl_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] count;
		logic                valid;
		logic                error;
	} tap_res_t;

endpackage

@@ src/mscb_lane.sv @@
// ----------------------------------------------------------------------------
// mscb_lane
// one beat stream: period register and fractional countdown
// ----------------------------------------------------------------------------
module mscb_lane
	import mscb_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                period_we,
	input  logic [PERIOD_W-1:0] period_wdata,
	input  lane_ctl_t           ctl,
	output logic                beat
);

	localparam int X_W = CD_W + 1;
	localparam logic [63:0]            RESET_PERIOD_64 = 64'(RESET_SAMPLES) << FRAC_BITS;
	localparam logic [PERIOD_W-1:0]    RESET_PERIOD    = RESET_PERIOD_64[PERIOD_W-1:0];
	localparam logic signed [X_W-1:0]  ONE_X  = X_W'(1) <<< FRAC_BITS;
	localparam logic signed [CD_W-1:0] ONE_C  = ONE_X[CD_W-1:0];
	localparam logic signed [X_W-1:0]  MIN_X  = -(X_W'(1) <<< (CD_W - 1));
	localparam logic signed [CD_W-1:0] MIN_C  = {1'b1, {(CD_W-1){1'b0}}};
	localparam logic signed [X_W-1:0]  RESET_PM1 =
		$signed({{(X_W-PERIOD_W){1'b0}}, RESET_PERIOD}) - ONE_X;

	logic [PERIOD_W-1:0]    period_q;
	logic signed [X_W-1:0]  pm1_q;     // period minus one sample
	logic signed [CD_W-1:0] cd_q;

	logic signed [X_W-1:0]  dec_x;
	logic                   under;
	logic signed [CD_W-1:0] dec_c;
	logic                   hit;
	logic signed [X_W-1:0]  reload_x;
	logic signed [CD_W-1:0] period_c;
	logic signed [CD_W-1:0] reload_c;

	assign period_c = $signed({{(CD_W-PERIOD_W){1'b0}}, period_q});
	assign dec_x    = $signed({cd_q[CD_W-1], cd_q}) - ONE_X;
	assign under    = dec_x < MIN_X;
	assign dec_c    = under ? MIN_C : dec_x[CD_W-1:0];
	assign hit      = dec_c <= $signed(CD_W'(0));
	// countdown minus one sample plus period, in parallel with the decrement
	assign reload_x = $signed({cd_q[CD_W-1], cd_q}) + pm1_q;
	assign reload_c = under ? (MIN_C + period_c) : reload_x[CD_W-1:0];

	assign beat = ctl.trig | (ctl.step & hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_PERIOD;
			pm1_q    <= RESET_PM1;
			cd_q     <= ONE_C;
		end else begin
			if (period_we) begin
				period_q <= period_wdata;
				pm1_q    <= $signed({{(X_W-PERIOD_W){1'b0}}, period_wdata}) - ONE_X;
			end
			if (ctl.trig) begin
				cd_q <= period_c;
			end else if (ctl.step) begin
				cd_q <= hit ? reload_c : dec_c;
			end else if (ctl.set_one) begin
				cd_q <= ONE_C;
			end
		end
	end

endmodule

@@ src/mscb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mscb_ctrl
// pause and tap state, decodes each transaction into lane commands
// ----------------------------------------------------------------------------
module mscb_ctrl
	import mscb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  kind_t     kind,
	input  logic      trigger,
	output lane_ctl_t lane_ctl,
	output tap_res_t  tap_res
);

	logic                paused_q;
	logic                listening_q;
	logic [PERIOD_W-1:0] tap_q;
	logic                tap_zero;

	assign tap_zero = tap_q == '0;

	always_comb begin
		lane_ctl = '0;
		tap_res  = '0;
		if (fire) begin
			case (kind)
				KIND_SAMPLE: begin
					if (!listening_q) begin
						if (trigger) begin
							lane_ctl.trig = 1'b1;
						end else if (!paused_q) begin
							lane_ctl.step = 1'b1;
						end
					end
				end
				KIND_ARM, KIND_TAP_START: begin
					lane_ctl.set_one = 1'b1;
				end
				KIND_TAP_END: begin
					if (tap_zero) begin
						tap_res.error = 1'b1;
					end else begin
						tap_res.count = tap_q;
						tap_res.valid = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q    <= 1'b0;
			listening_q <= 1'b0;
			tap_q       <= '0;
		end else if (fire) begin
			case (kind)
				KIND_SAMPLE: begin
					if (listening_q) begin
						if (tap_q != '1) begin
							tap_q <= tap_q + PERIOD_W'(1);
						end
					end else if (trigger) begin
						paused_q <= 1'b0;
					end
				end
				KIND_ARM, KIND_PAUSE: begin
					paused_q <= 1'b1;
				end
				KIND_RESUME: begin
					paused_q <= 1'b0;
				end
				KIND_TAP_START: begin
					listening_q <= 1'b1;
					paused_q    <= 1'b1;
					tap_q       <= '0;
				end
				KIND_TAP_END: begin
					if (!tap_zero) begin
						listening_q <= 1'b0;
						paused_q    <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ src/multi_stream_beat_clock.sv @@
// ----------------------------------------------------------------------------
// multi_stream_beat_clock
// several fractional beat streams driven by a per-sample stream with a tap timer
// ----------------------------------------------------------------------------
// pipeline: an accepted transaction is held in the input register,
//   then its result is loaded into the result register and offered on m_tvalid
// throughput: one transaction per cycle while m_tready is high, set by the
//   combinational countdown update of every lane between input and output registers
// reset: arst_n clears both pipeline stages, unpauses, stops tapping, loads
//   every countdown with one sample and every period with 22050 samples
module multi_stream_beat_clock
	import mscb_pkg::*;
#(
	parameter int STREAMS   = 4,
	parameter int FRAC_BITS = 8,
	localparam int IDX_W    = (STREAMS > 1) ? $clog2(STREAMS) : 1,
	localparam int OUT_W    = STREAMS + PERIOD_W + 2,
	localparam int OUT_BW   = ((OUT_W + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,

	// config write port, period of stream cfg_idx
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_idx,
	input  logic [PERIOD_W-1:0] cfg_data,

	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [2:0] kind
	input  logic                s_tuser,   // [0] trigger

	// output stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BW-1:0]   m_tdata    // beats, tap_count, tap_valid, tap_error
);

	// input stage
	logic  valid_s1;
	kind_t kind_s1;
	logic  trigger_s1;

	// output stage
	logic                valid_s2;
	logic [STREAMS-1:0]  beats_s2;
	tap_res_t            tap_s2;

	logic                advance;
	lane_ctl_t           lane_ctl;
	tap_res_t            tap_res;
	logic [STREAMS-1:0]  beats;

	// the input stage moves on whenever the output register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_BW'({tap_s2.error, tap_s2.valid, tap_s2.count, beats_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload captured with each accepted transaction
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1    <= kind_t'(s_tdata[KIND_W-1:0]);
			trigger_s1 <= s_tuser;
		end
	end

	// pause, tap and command decode
	mscb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.kind     (kind_s1),
		.trigger  (trigger_s1),
		.lane_ctl (lane_ctl),
		.tap_res  (tap_res)
	);

	// one countdown lane per stream, all stepping together
	for (genvar i = 0; i < STREAMS; i++) begin : g_lane
		mscb_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.period_we    (cfg_we && (cfg_idx == IDX_W'(i))),
			.period_wdata (cfg_data),
			.ctl          (lane_ctl),
			.beat         (beats[i])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beats_s2 <= beats;
			tap_s2   <= tap_res;
		end
	end

	// a tap end never reports a count and an error together
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(tap_s2.valid && tap_s2.error))
		else $error("tap valid and tap error both set");

	// beats come only from sample transactions, which carry no tap result
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (beats_s2 != '0)) |-> (!tap_s2.valid && !tap_s2.error && tap_s2.count == '0))
		else $error("beats mixed with a tap result");

	// an error result carries a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && tap_s2.error) |-> (tap_s2.count == '0))
		else $error("tap error with nonzero count");

	// an empty input stage always takes a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while empty");

	// a transaction that leaves the input stage shows up as a result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result lost after advance");

endmodule
